/* hdl/lpp_pkg.sv */
`default_nettype none

package lpp_pkg;

   localparam int DEF_BLOCKS         = 6;
   localparam int DEF_LASERS         = 40;
   localparam int DEF_RESERVED_BYTES = 8;

   localparam int MEASURE_BYTES = 5;
   localparam int BLOCK_HEAD    = 4;
   localparam int TAIL_BYTES    = 8;

   localparam int BLOCK_W = 4;
   localparam int LASER_W = 6;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [23:0] BUG_RANGE   = 24'h010101;
   localparam logic [15:0] BUG_REFL    = 16'h0101;
   localparam logic [23:0] RANGE_RESET = 24'(200 * 1000 / 2);

   localparam int RSP_TDATA_W = 152;
   localparam int CSR_ADDR_W  = 3;

   typedef enum logic [0:0] {
      REG_MAX_RANGE = 1'b0
   } lpp_reg_type;

   typedef enum logic [1:0] {
      KIND_MEASURE = 2'd0,
      KIND_TRAILER = 2'd1,
      KIND_ERROR   = 2'd2
   } lpp_kind_type;

   typedef struct packed {
      lpp_kind_type kind;
      logic [2:0]   block_index;
      logic [5:0]   laser_index;
      logic [15:0]  block_marker;
      logic [15:0]  azimuth;
      logic [23:0]  range_raw;
      logic [15:0]  reflectivity;
      logic [15:0]  revolution;
      logic [31:0]  timestamp_us;
      logic [15:0]  factory_id;
   } lpp_cmd_type;

endpackage

`default_nettype wire

/* hdl/lpp_front.sv */
`default_nettype none

module lpp_front #(
   parameter int BLOCKS         = lpp_pkg::DEF_BLOCKS,
   parameter int LASERS         = lpp_pkg::DEF_LASERS,
   parameter int RESERVED_BYTES = lpp_pkg::DEF_RESERVED_BYTES
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          data_byte,
   input  wire logic                end_of_packet,
   output logic                     push,
   output lpp_pkg::lpp_cmd_type     cmd
);

   import lpp_pkg::*;

   localparam int BLOCK_BYTES = BLOCK_HEAD + MEASURE_BYTES * LASERS;
   localparam int DATA_BYTES  = BLOCKS * BLOCK_BYTES;
   localparam int TAIL_START  = DATA_BYTES + RESERVED_BYTES;
   localparam int PKT_LEN     = TAIL_START + TAIL_BYTES;
   localparam int POS_W       = $clog2(PKT_LEN + 1);
   localparam int OFF_W       = $clog2(BLOCK_BYTES);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [2:0]         sub_ff, sub_in;
   logic [LASER_W-1:0] laser_ff, laser_in;
   logic [BLOCK_W-1:0] blk_ff, blk_in;
   logic [31:0]        shift_ff, shift_in;
   logic [15:0]        marker_ff, marker_in;
   logic [15:0]        azimuth_ff, azimuth_in;
   logic [15:0]        rev_ff, rev_in;
   logic [31:0]        ts_ff, ts_in;
   logic [15:0]        fact_ff, fact_in;
   logic               overrun_ff, overrun_in;

   logic               in_data;
   logic               in_tail;
   logic               in_over;
   logic [POS_W-1:0]   tail_off;
   logic [2:0]         t;
   logic [1:0]         ts_sel;
   logic               measure_done;
   logic               pkt_ok;

   assign in_over  = pos_ff >= POS_W'(PKT_LEN);
   assign in_data  = pos_ff < POS_W'(DATA_BYTES);
   assign in_tail  = !in_data && !in_over && (pos_ff >= POS_W'(TAIL_START));
   assign tail_off = pos_ff - POS_W'(TAIL_START);
   assign t        = tail_off[2:0];
   assign ts_sel   = t[1:0] - 2'd2;
   assign pkt_ok   = !overrun_in && (pos_ff == POS_W'(PKT_LEN - 1));

   always_comb begin
      pos_in       = pos_ff;
      off_in       = off_ff;
      sub_in       = sub_ff;
      laser_in     = laser_ff;
      blk_in       = blk_ff;
      shift_in     = shift_ff;
      marker_in    = marker_ff;
      azimuth_in   = azimuth_ff;
      rev_in       = rev_ff;
      ts_in        = ts_ff;
      fact_in      = fact_ff;
      overrun_in   = overrun_ff;
      measure_done = 1'b0;
      if (accept) begin
         if (in_over) begin
            overrun_in = 1'b1;
         end else if (in_data) begin
            if (off_ff < OFF_W'(2)) begin
               marker_in[8*off_ff[0] +: 8] = data_byte;
            end else if (off_ff < OFF_W'(BLOCK_HEAD)) begin
               azimuth_in[8*off_ff[0] +: 8] = data_byte;
            end else begin
               if (sub_ff == 3'(MEASURE_BYTES - 1)) begin
                  measure_done = 1'b1;
                  sub_in       = 3'd0;
                  laser_in     = laser_ff + LASER_W'(1);
               end else begin
                  shift_in[8*sub_ff[1:0] +: 8] = data_byte;
                  sub_in = sub_ff + 3'd1;
               end
            end
            if (off_ff == OFF_W'(BLOCK_BYTES - 1)) begin
               off_in   = '0;
               sub_in   = 3'd0;
               laser_in = '0;
               blk_in   = blk_ff + BLOCK_W'(1);
            end else begin
               off_in = off_ff + OFF_W'(1);
            end
         end else if (in_tail) begin
            if (t < 3'd2) begin
               rev_in[8*t[0] +: 8] = data_byte;
            end else if (t < 3'd6) begin
               ts_in[8*ts_sel +: 8] = data_byte;
            end else begin
               fact_in[8*t[0] +: 8] = data_byte;
            end
         end
         if (!in_over) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_comb begin
      push = 1'b0;
      cmd  = '0;
      if (accept && end_of_packet) begin
         push = 1'b1;
         if (pkt_ok) begin
            cmd.kind         = KIND_TRAILER;
            cmd.revolution   = rev_in;
            cmd.timestamp_us = ts_in;
            cmd.factory_id   = fact_in;
         end else begin
            cmd.kind = KIND_ERROR;
         end
      end else if (measure_done) begin
         push              = 1'b1;
         cmd.kind          = KIND_MEASURE;
         cmd.block_index   = blk_ff[2:0];
         cmd.laser_index   = laser_ff;
         cmd.block_marker  = marker_ff;
         cmd.azimuth       = azimuth_ff;
         cmd.range_raw     = shift_ff[23:0];
         cmd.reflectivity  = {data_byte, shift_ff[31:24]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_packet)) begin
         pos_ff     <= '0;
         off_ff     <= '0;
         sub_ff     <= '0;
         laser_ff   <= '0;
         blk_ff     <= '0;
         shift_ff   <= '0;
         marker_ff  <= '0;
         azimuth_ff <= '0;
         rev_ff     <= '0;
         ts_ff      <= '0;
         fact_ff    <= '0;
         overrun_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         off_ff     <= off_in;
         sub_ff     <= sub_in;
         laser_ff   <= laser_in;
         blk_ff     <= blk_in;
         shift_ff   <= shift_in;
         marker_ff  <= marker_in;
         azimuth_ff <= azimuth_in;
         rev_ff     <= rev_in;
         ts_ff      <= ts_in;
         fact_ff    <= fact_in;
         overrun_ff <= overrun_in;
      end
   end

`ifndef SYNTHESIS
   a_eop_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_packet) |=> (pos_ff == '0) && !overrun_ff)
      else $error("position not cleared after end of packet");
   a_overrun_pos: assert property (@(posedge clock) disable iff (reset)
      overrun_ff |-> (pos_ff == POS_W'(PKT_LEN)))
      else $error("overrun flagged before packet length reached");
   a_off_range: assert property (@(posedge clock) disable iff (reset)
      off_ff < OFF_W'(BLOCK_BYTES))
      else $error("block offset out of range");
`endif

endmodule

`default_nettype wire

/* hdl/lpp_queue.sv */
`default_nettype none

module lpp_queue #(
   parameter int DEPTH = lpp_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lpp_pkg::lpp_cmd_type push_cmd,
   output logic                      full,
   output logic                      q_valid,
   output lpp_pkg::lpp_cmd_type      q_cmd,
   input  wire logic                 pop
);

   import lpp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   lpp_cmd_type      slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign q_valid = count_ff != '0;
   assign q_cmd   = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

/* hdl/lpp_back.sv */
`default_nettype none

module lpp_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [23:0]                    max_range_raw,
   input  wire logic                           q_valid,
   input  wire lpp_pkg::lpp_cmd_type           q_cmd,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [lpp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast
);

   import lpp_pkg::*;

   logic        valid_ff, valid_in;
   lpp_cmd_type out_ff, out_in;
   logic        bad_measure;

   assign bad_measure = (q_cmd.kind == KIND_MEASURE) &&
                        (((q_cmd.range_raw == BUG_RANGE) && (q_cmd.reflectivity == BUG_REFL))
                         || (q_cmd.range_raw > max_range_raw));

   assign pop = q_valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      out_in   = out_ff;
      if (pop) begin
         valid_in = 1'b1;
         out_in   = q_cmd;
         if (bad_measure) begin
            out_in.range_raw    = '0;
            out_in.reflectivity = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.kind != KIND_MEASURE;
   assign rsp_tdata  = {7'b0, out_ff.factory_id, out_ff.timestamp_us, out_ff.revolution,
                        out_ff.reflectivity, out_ff.range_raw, out_ff.azimuth,
                        out_ff.block_marker, out_ff.laser_index, out_ff.block_index};

`ifndef SYNTHESIS
   a_refill: assert property (@(posedge clock) disable iff (reset)
      (q_valid && (!valid_ff || rsp_tready)) |=> valid_ff)
      else $error("queued beat not moved to output register");
`endif

endmodule

`default_nettype wire

/* hdl/lidar_packet_parser.sv */
// Lidar packet parser, single-return format.
// req channel: one packet byte per beat in req_tdata, req_tlast on the final byte.
// rsp channel: one beat per completed five-byte measure (tuser = measure), and one
//   closing beat per packet with tlast high (tuser = trailer, or length error).
// Measures whose range exceeds max_range_raw, or that match the 0x010101/0x0101
//   pattern, carry zero range and reflectivity. On a length error, downstream
//   drops the measures already delivered for that packet.
// csr port: register 0 at byte address 0 is max_range_raw (24 bits, reset 100000);
//   write it only while no packet is in flight.
// Throughput: one byte per cycle while the result queue is not full. With nothing
//   waiting, the edge that accepts a byte writes its result into the 4-entry result
//   queue, and the next edge loads it into the output register that drives rsp.
// Stall: while rsp_tready is low the output register holds its beat and the queue
//   fills; req_tready falls only once the queue is full.
// Reset: synchronous, active high; clears the packet position and the queue and
//   loads max_range_raw with its reset value.
`default_nettype none

module lidar_packet_parser #(
   parameter int BLOCKS         = lpp_pkg::DEF_BLOCKS,
   parameter int LASERS         = lpp_pkg::DEF_LASERS,
   parameter int RESERVED_BYTES = lpp_pkg::DEF_RESERVED_BYTES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,  // data_byte
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // block_index, laser_index, block_marker, azimuth, range_raw, reflectivity,
   // revolution, timestamp_us, factory_id, zero pad
   output logic [lpp_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic [1:0]                             rsp_tuser,  // kind
   output logic                                   rsp_tlast,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [lpp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   import lpp_pkg::*;

   logic        accept;
   logic        push;
   lpp_cmd_type push_cmd;
   logic        full;
   logic        q_valid;
   lpp_cmd_type q_cmd;
   logic        pop;
   logic [23:0] max_range_ff, max_range_in;
   lpp_reg_type reg_sel;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !full;
   assign csr_pready = 1'b1;
   assign reg_sel    = lpp_reg_type'(csr_paddr[2]);

   always_comb begin
      max_range_in = max_range_ff;
      if (csr_psel && csr_penable && csr_pwrite && (reg_sel == REG_MAX_RANGE)) begin
         max_range_in = csr_pwdata[23:0];
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MAX_RANGE: csr_prdata = {8'b0, max_range_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= RANGE_RESET;
      end else begin
         max_range_ff <= max_range_in;
      end
   end

   lpp_front #(
      .BLOCKS         (BLOCKS),
      .LASERS         (LASERS),
      .RESERVED_BYTES (RESERVED_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_tdata),
      .end_of_packet (req_tlast),
      .push          (push),
      .cmd           (push_cmd)
   );

   lpp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .pop      (pop)
   );

   lpp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .max_range_raw (max_range_ff),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

`default_nettype wire
